@@ design/bmi_pkg.sv @@
// Shared constants, types and helpers for the bilinear map interpolator.
package bmi_pkg;

    localparam int MAP_DIM   = 16;
    localparam int FRAC_BITS = 8;

    localparam int MAP_SIZE  = MAP_DIM * MAP_DIM;
    localparam int ADDR_W    = $clog2(MAP_SIZE);
    localparam int COORD_ONE = 1 << FRAC_BITS;
    localparam int COORD_MAX = (MAP_DIM - 1) << FRAC_BITS;
    localparam int CL_W      = $clog2(COORD_MAX + 1);
    localparam int IDX_W     = CL_W - FRAC_BITS;
    localparam int WGT_W     = FRAC_BITS + 1;
    localparam int PROD_W    = 16 + WGT_W;
    localparam int H_W       = 16 + FRAC_BITS;
    localparam int SUM_W     = 16 + 2 * FRAC_BITS;
    localparam int LSH       = (2 * FRAC_BITS < 16) ? 16 - 2 * FRAC_BITS : 0;
    localparam int RSH       = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
    localparam int EXT_W     = SUM_W + LSH + 1;
    localparam int RND_HALF  = (RSH > 0) ? (1 << (RSH - 1)) : 0;

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [FRAC_BITS-1:0] frac_t;

    typedef struct packed {
        logic            func;
        logic [3:0][ADDR_W-1:0] addr;
        logic [15:0]     data;
        frac_t           fx;
        frac_t           fy;
    } bmi_cmd_t;

    function automatic addr_t map_addr(int r, int c);
        return ADDR_W'(r * MAP_DIM + c);
    endfunction

    function automatic logic [CL_W-1:0] clamp_coord(logic signed [15:0] c);
        logic [CL_W-1:0] res;
        if (int'(c) < 0)
            res = '0;
        else if (int'(c) > COORD_MAX)
            res = CL_W'(COORD_MAX);
        else
            res = CL_W'(c);
        return res;
    endfunction

    function automatic logic [31:0] scale_sum(logic [SUM_W-1:0] s);
        logic [EXT_W-1:0] t;
        t = EXT_W'(s);
        t = (t + EXT_W'(RND_HALF)) >> RSH;
        t = t << LSH;
        return t[31:0];
    endfunction

endpackage

@@ design/bmi_req_if.sv @@
// Request channel: map writes and lookups.
interface bmi_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [15:0] entry_value;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;

    modport source (output valid, func, row, col, entry_value, coord_x, coord_y,
                    input ready);
    modport sink   (input valid, func, row, col, entry_value, coord_x, coord_y,
                    output ready);
endinterface

@@ design/bmi_rsp_if.sv @@
// Response channel: interpolated values.
interface bmi_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] interp_value;

    modport source (output valid, interp_value, input ready);
    modport sink   (input valid, interp_value, output ready);
endinterface

@@ design/bmi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bmi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

@@ design/bmi_front.sv @@
// Front end: accept transactions, clamp coordinates and form map addresses.
module bmi_front import bmi_pkg::*; (
    bmi_req_if.sink    req,
    input  logic       full,
    output logic       push,
    output bmi_cmd_t   cmd
);
    logic [CL_W-1:0]  cx, cy;
    logic [IDX_W-1:0] ix, iy, ix1, iy1;
    logic             in_map;

    always_comb
    begin
        cx  = clamp_coord(req.coord_x);
        cy  = clamp_coord(req.coord_y);
        ix  = cx[CL_W-1:FRAC_BITS];
        iy  = cy[CL_W-1:FRAC_BITS];
        ix1 = (int'(ix) < MAP_DIM - 1) ? IDX_W'(ix + 1'b1) : ix;
        iy1 = (int'(iy) < MAP_DIM - 1) ? IDX_W'(iy + 1'b1) : iy;
        in_map = (int'(req.row) < MAP_DIM) && (int'(req.col) < MAP_DIM);

        cmd.func = req.func;
        cmd.data = req.entry_value;
        cmd.fx   = cx[FRAC_BITS-1:0];
        cmd.fy   = cy[FRAC_BITS-1:0];
        if (req.func == FUNC_WRITE)
        begin
            cmd.addr[0] = map_addr(int'(req.row), int'(req.col));
            cmd.addr[1] = cmd.addr[0];
            cmd.addr[2] = cmd.addr[0];
            cmd.addr[3] = cmd.addr[0];
        end
        else
        begin
            cmd.addr[0] = map_addr(int'(iy),  int'(ix));
            cmd.addr[1] = map_addr(int'(iy),  int'(ix1));
            cmd.addr[2] = map_addr(int'(iy1), int'(ix));
            cmd.addr[3] = map_addr(int'(iy1), int'(ix1));
        end
    end

    assign req.ready = !full;
    assign push      = req.valid && !full && (req.func == FUNC_LOOKUP || in_map);
endmodule

@@ design/bmi_queue.sv @@
// Short command queue between front and back ends.
module bmi_queue import bmi_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  bmi_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output bmi_cmd_t pop_cmd,
    output logic     empty
);
    bmi_cmd_t             slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : Q_PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : Q_PTR_W'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = Q_CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = Q_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full    = (int'(count_reg) == Q_DEPTH);
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> int'(count_reg) != Q_DEPTH)
        else $error("queue pushed while full");
endmodule

@@ design/bmi_back.sv @@
// Back end: map storage, neighbour reads and the two-step bilinear blend.
module bmi_back import bmi_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        empty,
    input  bmi_cmd_t    cmd,
    output logic        pop,
    bmi_rsp_if.source   rsp
);
    logic             adv;
    logic             rd_en;
    logic             wr_en;
    logic [3:0][15:0] q;

    logic             valid_a_reg, valid_a_next;
    frac_t            fx_a_reg, fy_a_reg;
    logic             valid_b_reg;
    logic [H_W-1:0]   h0_reg, h0_next, h1_reg, h1_next;
    frac_t            fy_b_reg;
    logic             out_valid_reg;
    logic [31:0]      out_value_reg, out_value_next;

    logic [WGT_W-1:0] wx0, wx1, wy0, wy1;
    logic [SUM_W-1:0] sum;

    assign adv   = !out_valid_reg || rsp.ready;
    assign pop   = !empty && adv;
    assign rd_en = pop && (cmd.func == FUNC_LOOKUP);
    assign wr_en = pop && (cmd.func == FUNC_WRITE);

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        bmi_ram #(.WIDTH(16), .DEPTH(MAP_SIZE)) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (cmd.addr[0]),
            .wr_data (cmd.data),
            .rd_en   (rd_en),
            .rd_addr (cmd.addr[g]),
            .rd_data (q[g])
        );
    end

    always_comb
    begin
        valid_a_next   = rd_en;
        wx1            = {1'b0, fx_a_reg};
        wx0            = WGT_W'(COORD_ONE) - wx1;
        h0_next        = H_W'(PROD_W'(q[0]) * PROD_W'(wx0) + PROD_W'(q[1]) * PROD_W'(wx1));
        h1_next        = H_W'(PROD_W'(q[2]) * PROD_W'(wx0) + PROD_W'(q[3]) * PROD_W'(wx1));
        wy1            = {1'b0, fy_b_reg};
        wy0            = WGT_W'(COORD_ONE) - wy1;
        sum            = SUM_W'(h0_reg) * SUM_W'(wy0) + SUM_W'(h1_reg) * SUM_W'(wy1);
        out_value_next = scale_sum(sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            valid_b_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg   <= valid_a_next;
            valid_b_reg   <= valid_a_reg;
            out_valid_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fx_a_reg      <= cmd.fx;
            fy_a_reg      <= cmd.fy;
            h0_reg        <= h0_next;
            h1_reg        <= h1_next;
            fy_b_reg      <= fy_a_reg;
            out_value_reg <= out_value_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.interp_value = out_value_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_a_reg) && $stable(valid_b_reg) && $stable(h0_reg))
        else $error("back pipeline moved while stalled");

    a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !valid_a_reg)
        else $error("map write entered the blend pipeline");

    a_blend_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        valid_b_reg && adv |=> out_valid_reg)
        else $error("blended value lost before output register");
endmodule

@@ design/bilinear_map_interpolator_core.sv @@
// Top level of the bilinear map interpolator.
//
//  Channel | Modport | Payload                                     | Transaction
//  req     | sink    | func, row, col, entry_value, coord_x/y      | valid & ready
//  rsp     | source  | interp_value (unsigned Q16.16)              | valid & ready
//
// One transaction per cycle sustained while rsp is ready; four RAM copies, one read
// port each, serve the four neighbours of a lookup in the same cycle.
// A lookup passes a queue slot and the RAM, h0/h1 and output registers; writes give none.
// Reset clears the queue and pipeline valid state; map contents are undefined until written.
// A stalled rsp holds the back end; the two-entry queue takes up to two more
// transactions, then req.ready drops until the back end advances again.
module bilinear_map_interpolator_core import bmi_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    bmi_req_if.sink   req,
    bmi_rsp_if.source rsp
);
    logic     push, full, pop, empty;
    bmi_cmd_t push_cmd, pop_cmd;

    bmi_front u_front (
        .req  (req),
        .full (full),
        .push (push),
        .cmd  (push_cmd)
    );

    bmi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    bmi_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .cmd   (pop_cmd),
        .pop   (pop),
        .rsp   (rsp)
    );
endmodule

@@ tb/bmi_interp_checker.sv @@
// Checker for the bilinear map interpolator: mirrors the map, predicts each lookup, compares.
module bmi_interp_checker import bmi_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bmi_req_if   req,
    bmi_rsp_if   rsp,
    output int   fail_count,
    output int   pending,
    output int   writes_seen,
    output int   lookups_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOW_LIMIT = 20;

    logic [15:0] map_shadow [MAP_SIZE];
    logic [31:0] interp_expected [$];
    int          n_fail;
    int          n_writes;
    int          n_lookups;

    assign fail_count   = n_fail;
    assign writes_seen  = n_writes;
    assign lookups_seen = n_lookups;

    function automatic logic [31:0] bilinear_blend(logic signed [15:0] x,
                                                   logic signed [15:0] y);
        int              cx, cy, ix, iy, ix1, iy1, rs;
        longint unsigned fx, fy, one, sum, scaled;
        cx = x;
        cy = y;
        if (cx < 0)
            cx = 0;
        else if (cx > COORD_MAX)
            cx = COORD_MAX;
        if (cy < 0)
            cy = 0;
        else if (cy > COORD_MAX)
            cy = COORD_MAX;
        ix  = cx >> FRAC_BITS;
        iy  = cy >> FRAC_BITS;
        fx  = cx & (COORD_ONE - 1);
        fy  = cy & (COORD_ONE - 1);
        ix1 = (ix < MAP_DIM - 1) ? ix + 1 : ix;
        iy1 = (iy < MAP_DIM - 1) ? iy + 1 : iy;
        one = COORD_ONE;
        sum = longint'(map_shadow[iy * MAP_DIM + ix])   * (one - fx) * (one - fy)
            + longint'(map_shadow[iy * MAP_DIM + ix1])  * fx * (one - fy)
            + longint'(map_shadow[iy1 * MAP_DIM + ix])  * (one - fx) * fy
            + longint'(map_shadow[iy1 * MAP_DIM + ix1]) * fx * fy;
        if (2 * FRAC_BITS <= 16)
        begin
            scaled = sum << (16 - 2 * FRAC_BITS);
        end
        else
        begin
            rs     = 2 * FRAC_BITS - 16;
            scaled = (sum + (64'd1 << (rs - 1))) >> rs;
        end
        return scaled[31:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [31:0] want;
        if (!rst_n)
        begin
            interp_expected.delete();
            n_fail    = 0;
            n_writes  = 0;
            n_lookups = 0;
            pending  <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (interp_expected.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= SHOW_LIMIT)
                        $display("%0t: result %h with no lookup outstanding",
                                 $time, rsp.interp_value);
                end
                else
                begin
                    want = interp_expected.pop_front();
                    if (rsp.interp_value !== want)
                    begin
                        n_fail++;
                        if (n_fail <= SHOW_LIMIT)
                            $display("%0t: interp_value expected %h actual %h",
                                     $time, want, rsp.interp_value);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                if (req.func == FUNC_WRITE)
                begin
                    map_shadow[int'(req.row) * MAP_DIM + int'(req.col)] = req.entry_value;
                    n_writes++;
                end
                else
                begin
                    interp_expected.push_back(bilinear_blend(req.coord_x, req.coord_y));
                    n_lookups++;
                end
            end
            pending <= interp_expected.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// Testbench top: clock, reset, map writes and lookups, back-pressure, watchdog and verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmi_pkg::*;

    localparam int IDLE_LIMIT  = 5000;
    localparam int PHASE_ITEMS = 480;

    logic clk = 1'b0;
    logic rst_n;
    int   req_gap_pct;
    int   rsp_stall_pct;
    int   fail_count;
    int   pending;
    int   writes_seen;
    int   lookups_seen;
    int   quiet_cycles = 0;

    bmi_req_if req_ch ();
    bmi_rsp_if rsp_ch ();

    always #4 clk = ~clk;

    bilinear_map_interpolator_core u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bmi_interp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req_ch),
        .rsp          (rsp_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .writes_seen  (writes_seen),
        .lookups_seen (lookups_seen)
    );

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    function automatic logic [15:0] rand_entry();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(9))
            5:       return 16'($urandom);
            6:       return -16'sd1 - 16'($urandom_range(1023));
            7:       return 16'($urandom_range(32767, COORD_MAX + 1));
            8:
            begin
                case ($urandom_range(6))
                    0:       return 16'sh0000;
                    1:       return 16'(COORD_MAX - 1);
                    2:       return 16'(COORD_MAX);
                    3:       return -16'sd1;
                    4:       return 16'sh8000;
                    5:       return 16'sh7FFF;
                    default: return 16'(COORD_ONE - 1);
                endcase
            end
            9:       return 16'($urandom_range(MAP_DIM - 1) << FRAC_BITS);
            default: return 16'($urandom_range(COORD_MAX));
        endcase
    endfunction

    task automatic send_item(input logic func, input logic [3:0] row, input logic [3:0] col,
                             input logic [15:0] value, input logic signed [15:0] x,
                             input logic signed [15:0] y);
        while ($urandom_range(99) < req_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= func;
        req_ch.row         <= row;
        req_ch.col         <= col;
        req_ch.entry_value <= value;
        req_ch.coord_x     <= x;
        req_ch.coord_y     <= y;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic put_entry(input int row, input int col, input logic [15:0] value);
        send_item(FUNC_WRITE, 4'(row), 4'(col), value, 16'($urandom), 16'($urandom));
    endtask

    task automatic lookup_at(input logic signed [15:0] x, input logic signed [15:0] y);
        send_item(FUNC_LOOKUP, 4'($urandom), 4'($urandom), 16'($urandom), x, y);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        req_gap_pct        = 17;
        rsp_stall_pct      = 61;
        req_ch.valid       = 1'b0;
        req_ch.func        = FUNC_WRITE;
        req_ch.row         = '0;
        req_ch.col         = '0;
        req_ch.entry_value = '0;
        req_ch.coord_x     = '0;
        req_ch.coord_y     = '0;
        rsp_ch.ready       = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // fill the four corner blocks, then blend inside them only
        put_entry(0, 0, 16'hFFFF);
        put_entry(0, 1, 16'h0000);
        put_entry(1, 0, 16'h0000);
        put_entry(1, 1, 16'hFFFF);
        put_entry(0, 14, 16'h1234);
        put_entry(0, 15, 16'hFFFF);
        put_entry(1, 14, 16'h8001);
        put_entry(1, 15, 16'h7FFE);
        put_entry(14, 0, 16'h0001);
        put_entry(14, 1, 16'hFFFE);
        put_entry(15, 0, 16'h5555);
        put_entry(15, 1, 16'hAAAA);
        put_entry(14, 14, 16'hFFFF);
        put_entry(14, 15, 16'hFFFF);
        put_entry(15, 14, 16'hFFFF);
        put_entry(15, 15, 16'hFFFF);
        lookup_at(16'sh8000, 16'sh8000);
        lookup_at(16'sh00FF, 16'sh00FF);
        lookup_at(16'sh0080, 16'sh0040);
        lookup_at(16'sh7FFF, 16'sh7FFF);
        lookup_at(16'sh0EFF, 16'sh0EFF);
        lookup_at(16'sh0F00, -16'sd1);
        lookup_at(-16'sd256, 16'sh0F80);
        lookup_at(16'sh0E80, 16'sh0F00);
        lookup_at(16'sh7FFF, 16'sh00FF);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    req_gap_pct   = 17;
                    rsp_stall_pct = 61;
                end
                1:
                begin
                    req_gap_pct   = 61;
                    rsp_stall_pct = 17;
                end
                default:
                begin
                    req_gap_pct   = 0;
                    rsp_stall_pct = 0;
                end
            endcase
            if (ph == 0)
                for (int r = 0; r < MAP_DIM; r++)
                    for (int c = 0; c < MAP_DIM; c++)
                        put_entry(r, c, rand_entry());
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(3) == 0)
                    put_entry($urandom_range(MAP_DIM - 1), $urandom_range(MAP_DIM - 1),
                              rand_entry());
                else
                    lookup_at(rand_coord(), rand_coord());
            end
        end
        req_ch.valid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);

        $display("run covered %0d map writes and %0d lookups, corners, clamping and",
                 writes_seen, lookups_seen);
        $display("last-index repeats, under three patterns of gaps and back-pressure");
        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
design/bmi_pkg.sv
design/bmi_req_if.sv
design/bmi_rsp_if.sv
design/bmi_ram.sv
design/bmi_front.sv
design/bmi_queue.sv
design/bmi_back.sv
design/bilinear_map_interpolator_core.sv
tb/bmi_interp_checker.sv
tb/tb.sv
